@@ hw/rtl/hsfc_pkg.sv @@
// Shared types, constants and functions of the humidity sensor frame checker.
package hsfc_pkg;

  typedef logic [2:0]  pos_t;
  typedef logic [7:0]  crc_t;
  typedef logic [15:0] word_t;
  typedef logic [30:0] prod_t;

  // Byte positions within one six-byte reply
  localparam pos_t POS_TEMP_MSB = 3'd0;
  localparam pos_t POS_TEMP_LSB = 3'd1;
  localparam pos_t POS_TEMP_CRC = 3'd2;
  localparam pos_t POS_HUM_MSB  = 3'd3;
  localparam pos_t POS_HUM_LSB  = 3'd4;
  localparam pos_t POS_HUM_CRC  = 3'd5;

  localparam crc_t CRC_INIT = 8'hFF;
  localparam crc_t CRC_POLY = 8'h31;

  localparam prod_t TEMP_SPAN = 31'd17500;
  localparam prod_t HUM_SPAN  = 31'd12500;
  localparam word_t TEMP_OFS  = 16'd4500;
  localparam word_t HUM_OFS   = 16'd600;

  typedef struct packed {
    word_t temp_word;
    word_t hum_word;
    logic  temp_ok;
    logic  hum_ok;
  } frame_t;

  // CRC-8, MSB first, one byte folded in
  function automatic crc_t crc8_byte(crc_t acc, logic [7:0] b);
    crc_t c;
    c = acc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  // floor(x / 65535) for x below 2^31: (x + (x >> 16) + 1) >> 16
  function automatic word_t div65535(prod_t x);
    logic [31:0] s;
    s = {1'b0, x} + 32'(x[30:16]) + 32'd1;
    return s[31:16];
  endfunction

endpackage

@@ hw/rtl/hsfc_if.sv @@
// Valid/ready channel interfaces for reply bytes and decoded results.
interface hsfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_start;

  modport source(output valid, output rx_byte, output frame_start, input ready);
  modport sink(input valid, input rx_byte, input frame_start, output ready);
endinterface

interface hsfc_out_if;
  logic               valid;
  logic               ready;
  logic signed [14:0] temp_centi;
  logic signed [14:0] hum_centi;
  logic               temp_ok;
  logic               hum_ok;

  modport source(output valid, output temp_centi, output hum_centi,
                 output temp_ok, output hum_ok, input ready);
  modport sink(input valid, input temp_centi, input hum_centi,
               input temp_ok, input hum_ok, output ready);
endinterface

@@ hw/rtl/hsfc_frame.sv @@
// Input register, reply byte tracking and CRC-8 check of both words.
module hsfc_frame (
  input  logic            clk,
  input  logic            rst,
  hsfc_in_if.sink         rx,
  output logic            frm_valid,
  input  logic            frm_ready,
  output hsfc_pkg::frame_t frm
);
  import hsfc_pkg::*;

  logic       s0_valid;
  logic [7:0] s0_byte;
  logic       s0_start;

  pos_t  byte_pos;
  crc_t  crc_acc;
  word_t temp_word;
  word_t hum_word;
  logic  temp_good;

  pos_t  pos;
  crc_t  crc_seed;
  crc_t  crc_new;
  logic  last;
  logic  s0_move;

  always_comb begin
    pos = s0_start ? POS_TEMP_MSB : byte_pos;
    if (pos > POS_HUM_CRC) begin
      pos = POS_TEMP_MSB;
    end
    crc_seed = (pos == POS_TEMP_MSB || pos == POS_HUM_MSB) ? CRC_INIT : crc_acc;
    crc_new  = crc8_byte(crc_seed, s0_byte);
    last     = (pos == POS_HUM_CRC);
    s0_move  = s0_valid && (!last || frm_ready);
  end

  assign rx.ready  = !s0_valid || s0_move;
  assign frm_valid = s0_valid && last;

  always_comb begin
    frm.temp_word = temp_word;
    frm.hum_word  = hum_word;
    frm.temp_ok   = temp_good;
    frm.hum_ok    = (crc_acc == s0_byte);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (rx.valid && rx.ready) begin
      s0_valid <= 1'b1;
    end else if (s0_move) begin
      s0_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      s0_byte  <= rx.rx_byte;
      s0_start <= rx.frame_start;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_pos  <= POS_TEMP_MSB;
      crc_acc   <= CRC_INIT;
      temp_word <= '0;
      hum_word  <= '0;
      temp_good <= 1'b0;
    end else if (s0_move) begin
      byte_pos <= last ? POS_TEMP_MSB : pos + 3'd1;
      case (pos)
        POS_TEMP_MSB: begin
          crc_acc   <= crc_new;
          temp_word <= {s0_byte, 8'h00};
        end
        POS_TEMP_LSB: begin
          crc_acc   <= crc_new;
          temp_word <= {temp_word[15:8], s0_byte};
        end
        POS_TEMP_CRC: begin
          temp_good <= (crc_acc == s0_byte);
          crc_acc   <= CRC_INIT;
        end
        POS_HUM_MSB: begin
          crc_acc  <= crc_new;
          hum_word <= {s0_byte, 8'h00};
        end
        POS_HUM_LSB: begin
          crc_acc  <= crc_new;
          hum_word <= {hum_word[15:8], s0_byte};
        end
        default: begin
          crc_acc <= CRC_INIT;
        end
      endcase
    end
  end

endmodule

@@ hw/rtl/hsfc_scale.sv @@
// Scaling of both raw words: product stage, then divide by 65535 and offset.
module hsfc_scale (
  input  logic             clk,
  input  logic             rst,
  input  logic             frm_valid,
  output logic             frm_ready,
  input  hsfc_pkg::frame_t frm,
  hsfc_out_if.source       res
);
  import hsfc_pkg::*;

  logic  s1_valid;
  prod_t t_prod;
  prod_t h_prod;
  logic  s1_temp_ok;
  logic  s1_hum_ok;

  logic  out_free;
  logic  s1_free;
  word_t t_quot;
  word_t h_quot;
  word_t t_diff;
  word_t h_diff;

  assign out_free  = !res.valid || res.ready;
  assign s1_free   = !s1_valid || out_free;
  assign frm_ready = s1_free;

  always_comb begin
    t_quot = div65535(t_prod);
    h_quot = div65535(h_prod);
    t_diff = t_quot - TEMP_OFS;
    h_diff = h_quot - HUM_OFS;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= frm_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (frm_valid && s1_free) begin
      t_prod     <= prod_t'(frm.temp_word) * TEMP_SPAN;
      h_prod     <= prod_t'(frm.hum_word) * HUM_SPAN;
      s1_temp_ok <= frm.temp_ok;
      s1_hum_ok  <= frm.hum_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (out_free) begin
      res.valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && out_free) begin
      res.temp_centi <= $signed(t_diff[14:0]);
      res.hum_centi  <= $signed(h_diff[14:0]);
      res.temp_ok    <= s1_temp_ok;
      res.hum_ok     <= s1_hum_ok;
    end
  end

endmodule

@@ hw/rtl/humidity_sensor_frame_checker.sv @@
// Top level: checks and decodes six-byte temperature/humidity sensor replies.
// Throughput: one reply byte per cycle while the scaling stage takes each frame; the frame check keeps state per byte.
// Path: the edge that accepts the sixth byte loads the input register, then the frame passes
// through the product register and then the result register, whose load raises res.valid.
// Reset (synchronous, active high) empties all stages, sets the byte position
// to zero and the running CRC to 0xFF.
module humidity_sensor_frame_checker (
  input  logic       clk,
  input  logic       rst,
  hsfc_in_if.sink    rx,
  hsfc_out_if.source res
);
  import hsfc_pkg::*;

  logic   frm_valid;
  logic   frm_ready;
  frame_t frm;

  hsfc_frame u_frame (
    .clk       (clk),
    .rst       (rst),
    .rx        (rx),
    .frm_valid (frm_valid),
    .frm_ready (frm_ready),
    .frm       (frm)
  );

  hsfc_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .frm_valid (frm_valid),
    .frm_ready (frm_ready),
    .frm       (frm),
    .res       (res)
  );

  // Converted values stay within the sensor's scale whatever the raw word
  a_temp_range: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (res.temp_centi >= -15'sd4500 && res.temp_centi <= 15'sd13000))
    else $error("temperature out of scale");

  a_hum_range: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (res.hum_centi >= -15'sd600 && res.hum_centi <= 15'sd11900))
    else $error("humidity out of scale");

  // A stalled result word holds until it is taken
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.ready) |=> (res.valid && $stable(res.temp_centi) &&
      $stable(res.hum_centi) && $stable(res.temp_ok) && $stable(res.hum_ok)))
    else $error("result word changed while stalled");

endmodule
